FILE: hw/rtl/prm_pkg.sv
// prm_pkg: constants, codes and beat layout for the packet rate meter.
// No dependencies; imported by packet_rate_meter_top and tb_top.
package prm_pkg;

    // Timebase and scaling
    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned TRIP_SCALE       = 1000;
    localparam int unsigned LINK_OVERHEAD    = 20;
    localparam int unsigned FCS_BYTES        = 4;
    // Counts below this are scaled before dividing
    localparam logic [31:0] SCALE_LIMIT      = 32'hFFFF_FFFF / TICKS_PER_SECOND;

    // Shared unit widths
    localparam int unsigned MUL_W  = 20;   // multiplier constant bits, covers 1e6
    localparam int unsigned DIV_W  = 64;   // dividend / quotient bits
    localparam int unsigned CNT_W  = 6;    // iteration counter

    // Beat layout
    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 64;
    localparam int unsigned CFG_IDX_W = 2;

    // Operation codes
    localparam logic [1:0] OP_BATCH  = 2'd0;
    localparam logic [1:0] OP_SINGLE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Statistic selectors
    localparam logic [3:0] SEL_LAST_TOTAL = 4'd3;
    localparam logic [3:0] SEL_LAST_RATE  = 4'd7;
    localparam logic [3:0] SEL_SECONDS    = 4'd8;
    localparam logic [1:0] TOT_PACKETS    = 2'd0;
    localparam logic [1:0] TOT_BYTES      = 2'd1;
    localparam logic [1:0] TOT_BITS       = 2'd2;
    localparam logic [1:0] TOT_LINK       = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_IGNORE    = 2'd0;
    localparam logic [1:0] REG_MAX       = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_LINK_FCS  = 2'd3;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_POST = 3'd4;

    // Job kinds for the shared unit
    localparam logic [1:0] JOB_TRIP    = 2'd0;  // mul by 1000, div by elapsed, compare
    localparam logic [1:0] JOB_RATE_LO = 2'd1;  // mul by ticks, div by window
    localparam logic [1:0] JOB_RATE_HI = 2'd2;  // div by window, mul by ticks
    localparam logic [1:0] JOB_SECS    = 2'd3;  // div window by ticks

endpackage

FILE: hw/rtl/packet_rate_meter_top.sv
// packet_rate_meter_top: packet/byte counters with rate reads and a rate trip.
// Depends on prm_pkg for constants, codes and beat layout.
// Arrivals, totals and clears give a result from the exec state after the input beat;
// a new beat is taken only when the sequencer is idle. Rates and trip checks run a
// shared shift-add/subtract unit (20 multiply plus 64 divide steps); seconds only divide.
// Sync active-low reset clears the counters and arms the threshold; no sweep.
module packet_rate_meter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [prm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    // input beats
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: now[31:0], pkt_count[47:32], byte_total[79:48], stat_select[83:80]
    input  logic [prm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op[1:0]
    input  logic [prm_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // result beats
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: value[63:0]
    output logic [prm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: tripped[0]
    output logic [0:0]                       m_axis_tuser
);
    import prm_pkg::*;

    // Config registers
    logic [31:0] r_ignore, r_max, r_thresh;
    logic        r_fcs;

    // Measurement state
    logic        r_started, r_armed;
    logic [31:0] r_first, r_last;
    logic [63:0] r_packets, r_bytes;

    // Latched input beat
    logic [1:0]  r_op;
    logic [31:0] r_now;
    logic [15:0] r_pkts;
    logic [31:0] r_btot;
    logic [3:0]  r_sel;

    // Sequencer and shared unit
    logic [2:0]       r_state;
    logic [1:0]       r_job;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_a;      // multiplicand / dividend-quotient
    logic [63:0]      r_p;      // product accumulator
    logic [31:0]      r_rem;
    logic [31:0]      r_dvs;
    logic [MUL_W-1:0] r_mult;

    // Output register
    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic        r_out_trip;

    // Combinational helpers
    logic [31:0] first_eff, elapsed, span, win;
    logic [63:0] pk_new, by_new, total, link_extra;
    logic        counted, trip_check, out_free;
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [31:0] rem_nx;
    logic [63:0] quo_nx, prod_nx;
    logic        trip_hit;

    assign s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_trip;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Arrival bookkeeping
    always_comb begin
        first_eff  = r_started ? r_first : r_now;
        elapsed    = r_now - first_eff;
        pk_new     = r_packets + ((r_op == OP_SINGLE) ? 64'd1 : {48'd0, r_pkts});
        by_new     = r_bytes + {32'd0, r_btot};
        counted    = (elapsed >= r_ignore) && ((r_op == OP_SINGLE) || (elapsed < r_max));
        trip_check = r_armed && (r_thresh != 32'd0) && (elapsed > 32'(TICKS_PER_SECOND));
    end

    // Read window and selected total
    always_comb begin
        span       = r_last - r_first;
        win        = (span > r_ignore) ? (span - r_ignore) : 32'd1;
        link_extra = r_packets * 64'(LINK_OVERHEAD)
                   + (r_fcs ? r_packets * 64'(FCS_BYTES) : 64'd0);
        unique case (r_sel[1:0])
            TOT_PACKETS: total = r_packets;
            TOT_BYTES:   total = r_bytes;
            TOT_BITS:    total = r_bytes << 3;
            TOT_LINK:    total = (r_bytes + link_extra) << 3;
            default:     total = r_packets;
        endcase
    end

    // Shared unit: one restoring divide step, one shift-add multiply step and the trip compare
    always_comb begin
        rem_sh   = {r_rem, r_a[63]};
        div_ge   = rem_sh >= {1'b0, r_dvs};
        rem_nx   = div_ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
        quo_nx   = {r_a[62:0], div_ge};
        prod_nx  = r_p + (r_mult[0] ? r_a : 64'd0);
        trip_hit = r_a > {32'd0, r_thresh};
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore <= 32'd0;
            r_max    <= 32'hFFFF_FFFF;
            r_thresh <= 32'd0;
            r_fcs    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IGNORE:    r_ignore <= i_cfg_data;
                REG_MAX:       r_max    <= i_cfg_data;
                REG_THRESHOLD: r_thresh <= i_cfg_data;
                REG_LINK_FCS:  r_fcs    <= i_cfg_data[0];
                default:       r_fcs    <= r_fcs;
            endcase
        end
    end

    // Latch the input beat
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_now  <= s_axis_tdata[31:0];
            r_pkts <= s_axis_tdata[47:32];
            r_btot <= s_axis_tdata[79:48];
            r_sel  <= s_axis_tdata[83:80];
            r_op   <= s_axis_tuser;
        end
    end

    // Sequencer, statistics and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_armed     <= 1'b1;
            r_first     <= 32'd0;
            r_last      <= 32'd0;
            r_packets   <= 64'd0;
            r_bytes     <= 64'd0;
            r_out_valid <= 1'b0;
            r_out_trip  <= 1'b0;
            r_out_value <= 64'd0;
            r_job       <= JOB_TRIP;
            r_cnt       <= '0;
        end else begin
            // drop the result once taken
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    // hold until the output register can take a result
                    if (out_free) begin
                        r_out_value <= 64'd0;
                        r_out_trip  <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        r_p         <= 64'd0;
                        r_rem       <= 32'd0;
                        r_cnt       <= '0;
                        priority if (r_op == OP_BATCH || r_op == OP_SINGLE) begin
                            r_started <= 1'b1;
                            r_first   <= first_eff;
                            if (counted) begin
                                r_packets <= pk_new;
                                r_bytes   <= by_new;
                                r_last    <= r_now;
                                if (r_op == OP_BATCH && trip_check) begin
                                    r_a         <= pk_new;
                                    r_mult      <= MUL_W'(TRIP_SCALE);
                                    r_dvs       <= elapsed;
                                    r_job       <= JOB_TRIP;
                                    r_out_valid <= r_out_valid && !m_axis_tready;
                                    r_state     <= ST_MUL;
                                end
                            end else if (r_op == OP_SINGLE || elapsed < r_max) begin
                                r_last <= r_now;
                            end
                        end else if (r_op == OP_READ) begin
                            priority if (r_sel <= SEL_LAST_TOTAL) begin
                                r_out_value <= total;
                            end else if (r_sel == SEL_SECONDS) begin
                                r_a         <= {32'd0, win};
                                r_dvs       <= 32'(TICKS_PER_SECOND);
                                r_job       <= JOB_SECS;
                                r_out_valid <= r_out_valid && !m_axis_tready;
                                r_state     <= ST_DIV;
                            end else if (r_sel <= SEL_LAST_RATE) begin
                                r_a         <= total;
                                r_dvs       <= win;
                                r_mult      <= MUL_W'(TICKS_PER_SECOND);
                                r_out_valid <= r_out_valid && !m_axis_tready;
                                if (total < {32'd0, SCALE_LIMIT}) begin
                                    r_job   <= JOB_RATE_LO;
                                    r_state <= ST_MUL;
                                end else begin
                                    r_job   <= JOB_RATE_HI;
                                    r_state <= ST_DIV;
                                end
                            end else begin
                                r_out_value <= 64'd0;
                            end
                        end else begin
                            // clear stats, keep the armed bit
                            r_started <= 1'b0;
                            r_first   <= 32'd0;
                            r_last    <= 32'd0;
                            r_packets <= 64'd0;
                            r_bytes   <= 64'd0;
                        end
                    end
                end
                ST_MUL: begin
                    // add shifted multiplicand for each set constant bit
                    r_p    <= prod_nx;
                    r_a    <= r_a << 1;
                    r_mult <= r_mult >> 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MUL_W - 1)) begin
                        r_cnt <= '0;
                        if (r_job == JOB_RATE_HI) begin
                            r_state <= ST_POST;
                        end else begin
                            r_a     <= prod_nx;
                            r_rem   <= 32'd0;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    // one quotient bit per cycle
                    r_rem <= rem_nx;
                    r_a   <= quo_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        r_cnt <= '0;
                        if (r_job == JOB_RATE_HI) begin
                            r_p     <= 64'd0;
                            r_state <= ST_MUL;
                        end else begin
                            r_state <= ST_POST;
                        end
                    end
                end
                ST_POST: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_trip  <= 1'b0;
                        r_state     <= ST_IDLE;
                        unique case (r_job)
                            JOB_TRIP: begin
                                r_out_value <= 64'd0;
                                if (trip_hit) begin
                                    r_out_trip <= 1'b1;
                                    r_armed    <= 1'b0;
                                    r_started  <= 1'b0;
                                    r_first    <= 32'd0;
                                    r_last     <= 32'd0;
                                    r_packets  <= 64'd0;
                                    r_bytes    <= 64'd0;
                                end
                            end
                            JOB_RATE_LO: r_out_value <= {32'd0, r_a[31:0]};
                            JOB_RATE_HI: r_out_value <= {32'd0, r_p[31:0]};
                            JOB_SECS:    r_out_value <= r_a;
                            default:     r_out_value <= 64'd0;
                        endcase
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // a tripped result always carries a zero value
    a_trip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0))
        else $error("tripped result with nonzero value");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dvs != 32'd0))
        else $error("divide step with zero divisor");

    // a trip disarms the threshold and restarts the measurement
    a_trip_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POST && r_job == JOB_TRIP && out_free && trip_hit)
        |=> (!r_armed && !r_started && r_packets == 64'd0 && m_axis_tuser[0]))
        else $error("trip did not clear the statistics");
`endif

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for packet_rate_meter_top. Drives arrivals, reads and clears
// on the input stream, models the meter locally and checks every result beat in order.
// Depends on prm_pkg and packet_rate_meter_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prm_pkg::*;

    localparam int unsigned     PHASES        = 12;
    localparam int unsigned     PHASE_ITEMS   = 150;
    localparam int unsigned     IDLE_PCT      = 18;
    localparam int unsigned     SETTLE_CYCLES = 120;
    localparam int unsigned     REPORT_CAP    = 100;
    localparam longint unsigned WATCHDOG_NS   = 20_000_000;
    // counts below this are scaled before the divide
    localparam logic [63:0]     SCALE_CAP     = 64'h0000_0000_FFFF_FFFF / TICKS_PER_SECOND;

    // Statistic selectors
    localparam logic [3:0] STAT_PKTS      = 4'd0;
    localparam logic [3:0] STAT_BYTES     = 4'd1;
    localparam logic [3:0] STAT_BITS      = 4'd2;
    localparam logic [3:0] STAT_LINK      = 4'd3;
    localparam logic [3:0] STAT_PKT_RATE  = 4'd4;
    localparam logic [3:0] STAT_BYTE_RATE = 4'd5;
    localparam logic [3:0] STAT_BIT_RATE  = 4'd6;
    localparam logic [3:0] STAT_LINK_RATE = 4'd7;
    localparam logic [3:0] STAT_SECS      = 4'd8;
    localparam logic [3:0] STAT_SPARE_HI  = 4'd15;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic [15:0] pkts;
        logic [31:0] bytes;
        logic [3:0]  sel;
    } meter_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic        tripped;
    } meter_result_t;

    typedef struct {
        bit            is_cfg;
        logic [1:0]    reg_idx;
        logic [31:0]   reg_val;
        meter_item_t   item;
        bit            typed;
        meter_result_t want;
    } script_row_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [31:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    bit                   no_idle = 1'b0;
    int unsigned          mismatch_count = 0;
    meter_result_t        due_readings[$];

    // Local copy of the meter: configuration
    logic [31:0] ign_ticks  = 32'd0;
    logic [31:0] max_window = 32'hFFFF_FFFF;
    logic [31:0] trip_rate  = 32'd0;
    logic        fcs_on     = 1'b1;
    // Local copy of the meter: measurement state
    logic        meas_started = 1'b0;
    logic [31:0] t_first      = 32'd0;
    logic [31:0] t_last       = 32'd0;
    logic [63:0] pkts_total   = 64'd0;
    logic [63:0] bytes_total  = 64'd0;
    logic        trip_armed   = 1'b1;

    packet_rate_meter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void wipe_counts();
        meas_started = 1'b0;
        t_first      = 32'd0;
        t_last       = 32'd0;
        pkts_total   = 64'd0;
        bytes_total  = 64'd0;
    endfunction

    // Packets, bytes, bits or link bits, all modulo 2^64
    function automatic logic [63:0] total_of_kind(logic [1:0] kind);
        logic [63:0] per_pkt;
        per_pkt = 64'(LINK_OVERHEAD + (fcs_on ? FCS_BYTES : 0));
        case (kind)
            TOT_LINK:  return (bytes_total + pkts_total * per_pkt) << 3;
            TOT_BITS:  return bytes_total << 3;
            TOT_BYTES: return bytes_total;
            default:   return pkts_total;
        endcase
    endfunction

    // Value of a read: totals, rates over the window, whole seconds of window, or zero for spare selectors
    function automatic logic [63:0] stat_value(logic [3:0] sel);
        logic [31:0] span;
        logic [63:0] win;
        logic [63:0] cnt;
        logic [31:0] rate;
        span = t_last - t_first;
        win  = (span > ign_ticks) ? 64'(span - ign_ticks) : 64'd1;
        if (sel <= STAT_LINK)
            return total_of_kind(sel[1:0]);
        if (sel == STAT_SECS)
            return win / TICKS_PER_SECOND;
        if (sel > STAT_SECS)
            return 64'd0;
        cnt = total_of_kind(sel[1:0]);
        if (cnt < SCALE_CAP)
            rate = 32'((cnt * TICKS_PER_SECOND) / win);
        else
            rate = 32'((cnt / win) * TICKS_PER_SECOND);
        return 64'(rate);
    endfunction

    // Advance the local meter by one accepted beat and return its result
    function automatic meter_result_t next_meter_reading(meter_item_t it);
        meter_result_t res;
        logic [31:0]   elapsed;
        logic [63:0]   pps;
        res = '0;
        case (it.op)
            OP_BATCH, OP_SINGLE: begin
                if (!meas_started) begin
                    meas_started = 1'b1;
                    t_first      = it.now;
                end
                elapsed = it.now - t_first;
                if (it.op == OP_SINGLE) begin
                    // single packets have no upper window
                    if (elapsed >= ign_ticks) begin
                        pkts_total  += 64'd1;
                        bytes_total += it.bytes;
                    end
                    t_last = it.now;
                end else if (elapsed >= ign_ticks && elapsed < max_window) begin
                    pkts_total  += it.pkts;
                    bytes_total += it.bytes;
                    t_last       = it.now;
                    if (trip_armed && trip_rate != 0 && elapsed > TICKS_PER_SECOND) begin
                        pps = (pkts_total * TRIP_SCALE) / elapsed;
                        if (pps > trip_rate) begin
                            trip_armed = 1'b0;
                            wipe_counts();
                            res.tripped = 1'b1;
                        end
                    end
                end else if (elapsed < max_window) begin
                    // outside the counting window: only the last time moves
                    t_last = it.now;
                end
            end
            OP_READ:  res.value = stat_value(it.sel);
            default:  wipe_counts();
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < REPORT_CAP)
            $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Write one register; the local copy follows at the same edge
    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_IGNORE:    ign_ticks  = val;
            REG_MAX:       max_window = val;
            REG_THRESHOLD: trip_rate  = val;
            default:       fcs_on     = val[0];
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one beat with random gaps ahead of it; queue its result once accepted
    task automatic send_item(input meter_item_t it, input bit typed,
                             input meter_result_t given);
        meter_result_t calc;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, it.sel, it.bytes, it.pkts, it.now};
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        calc = next_meter_reading(it);
        due_readings.push_back(typed ? given : calc);
    endtask

    // Hold the input side until every queued result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_readings.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic script_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
        script_row_t r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic script_row_t item_row(logic [1:0] op, logic [31:0] now,
                                             logic [15:0] pkts, logic [31:0] bytes,
                                             logic [3:0] sel);
        script_row_t r;
        r            = '{default: '0};
        r.item.op    = op;
        r.item.now   = now;
        r.item.pkts  = pkts;
        r.item.bytes = bytes;
        r.item.sel   = sel;
        return r;
    endfunction

    function automatic script_row_t known_row(logic [1:0] op, logic [31:0] now,
                                              logic [15:0] pkts, logic [31:0] bytes,
                                              logic [3:0] sel, logic [63:0] value,
                                              logic trip);
        script_row_t r;
        r              = item_row(op, now, pkts, bytes, sel);
        r.typed        = 1'b1;
        r.want.value   = value;
        r.want.tripped = trip;
        return r;
    endfunction

    // Result side: random back-pressure except during the no-idle stretch
    always @(posedge i_clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each result beat with the oldest queued reading
    always @(posedge i_clk) begin
        meter_result_t want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (due_readings.size() == 0) begin
                flag_mismatch("result beat with nothing pending", m_axis_tdata, 64'd0);
            end else begin
                want = due_readings.pop_front();
                if (m_axis_tdata !== want.value)
                    flag_mismatch("value", m_axis_tdata, want.value);
                if (m_axis_tuser[0] !== want.tripped)
                    flag_mismatch("tripped", 64'(m_axis_tuser), 64'(want.tripped));
            end
        end
    end

    initial begin
        script_row_t   script[$];
        meter_item_t   it;
        meter_result_t no_result;
        logic [31:0]   clock_now;
        logic [31:0]   cfg_val;
        logic [95:0]   noise;
        int unsigned   pick;

        no_result = '0;

        // Directed: empty meter, extremes of the fields, every read, trip, windows
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_PKTS, 64'd0, 1'b0));
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_SECS, 64'd0, 1'b0));
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_LINK_RATE, 64'd0, 1'b0));
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_SPARE_HI, 64'd0, 1'b0));
        script.push_back(known_row(OP_BATCH, 32'd100, 16'hFFFF, 32'hFFFF_FFFF, STAT_PKTS,
                                   64'd0, 1'b0));
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_PKTS, 64'd65535, 1'b0));
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_BYTES,
                                   64'h0000_0000_FFFF_FFFF, 1'b0));
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_BITS,
                                   64'h0000_0007_FFFF_FFF8, 1'b0));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_LINK));
        // single packet at the top of the time range
        script.push_back(item_row(OP_SINGLE, 32'hFFFF_FFFF, 16'd0, 32'd1500, STAT_PKTS));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_PKT_RATE));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_BYTE_RATE));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_BIT_RATE));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_SECS));
        script.push_back(known_row(OP_CLEAR, 32'd0, 16'd0, 32'd0, STAT_PKTS, 64'd0, 1'b0));
        // ignore window then a rate trip once past one second
        script.push_back(cfg_row(REG_IGNORE, 32'd50));
        script.push_back(cfg_row(REG_THRESHOLD, 32'd1));
        script.push_back(item_row(OP_BATCH, 32'd1000, 16'd10, 32'd640, STAT_PKTS));
        script.push_back(item_row(OP_BATCH, 32'd1040, 16'd10, 32'd640, STAT_PKTS));
        script.push_back(item_row(OP_BATCH, 32'd1100, 16'd10, 32'd640, STAT_PKTS));
        script.push_back(known_row(OP_BATCH, 32'd3000, 16'd5000, 32'd320000, STAT_PKTS,
                                   64'd0, 1'b1));
        script.push_back(known_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_PKTS, 64'd0, 1'b0));
        // batch past the max window is dropped, single packet still counts
        script.push_back(cfg_row(REG_MAX, 32'd500));
        script.push_back(item_row(OP_BATCH, 32'd10, 16'd3, 32'd192, STAT_PKTS));
        script.push_back(item_row(OP_BATCH, 32'd600, 16'd7, 32'd448, STAT_PKTS));
        script.push_back(item_row(OP_SINGLE, 32'd700, 16'd9, 32'd64, STAT_PKTS));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_SECS));
        script.push_back(cfg_row(REG_LINK_FCS, 32'd0));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_LINK));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_LINK_RATE));
        // extreme windows: nothing counted by batches
        script.push_back(cfg_row(REG_IGNORE, 32'hFFFF_FFFF));
        script.push_back(cfg_row(REG_MAX, 32'd0));
        script.push_back(item_row(OP_BATCH, 32'd5, 16'd4, 32'd256, STAT_PKTS));
        script.push_back(item_row(OP_SINGLE, 32'd4, 16'd1, 32'd60, STAT_PKTS));
        script.push_back(item_row(OP_READ, 32'd0, 16'd0, 32'd0, STAT_BYTE_RATE));
        script.push_back(cfg_row(REG_LINK_FCS, 32'hFFFF_FFFF));
        script.push_back(known_row(OP_CLEAR, 32'd0, 16'd0, 32'd0, STAT_PKTS, 64'd0, 1'b0));

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                wait_drained();
                write_register(script[i].reg_idx, script[i].reg_val);
            end else begin
                send_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        // Random phases, each under fresh register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0:       cfg_val = 32'd0;
                1:       cfg_val = 32'hFFFF_FFFF;
                2:       cfg_val = $urandom();
                default: cfg_val = $urandom_range(0, 300);
            endcase
            write_register(REG_IGNORE, cfg_val);
            case ($urandom_range(0, 5))
                0:       cfg_val = 32'hFFFF_FFFF;
                1:       cfg_val = 32'd0;
                2:       cfg_val = $urandom();
                default: cfg_val = $urandom_range(200, 4000);
            endcase
            write_register(REG_MAX, cfg_val);
            case ($urandom_range(0, 3))
                0:       cfg_val = 32'd0;
                1:       cfg_val = 32'hFFFF_FFFF;
                default: cfg_val = $urandom();
            endcase
            write_register(REG_THRESHOLD, cfg_val);
            write_register(REG_LINK_FCS, $urandom());

            // first phase walks time across the 32-bit wrap
            clock_now = (ph == 0) ? 32'hFFFF_FE00 : $urandom();
            no_idle   = (ph == 3);

            noise    = {$urandom(), $urandom(), $urandom()};
            it       = noise[$bits(meter_item_t)-1:0];
            it.op    = OP_CLEAR;
            if ($urandom_range(0, 3) != 0)
                send_item(it, 1'b0, no_result);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off the sender until the block has emptied once
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
                noise = {$urandom(), $urandom(), $urandom()};
                it    = noise[$bits(meter_item_t)-1:0];
                pick  = $urandom_range(0, 99);
                if (pick < 45) begin
                    clock_now += $urandom_range(0, 400);
                    it.op      = OP_BATCH;
                    it.now     = clock_now;
                    if ($urandom_range(0, 9) != 0) begin
                        it.pkts  = 16'($urandom_range(1, 64));
                        it.bytes = it.pkts * $urandom_range(60, 1500);
                    end
                end else if (pick < 60) begin
                    clock_now += $urandom_range(0, 400);
                    it.op      = OP_SINGLE;
                    it.now     = clock_now;
                    if ($urandom_range(0, 9) != 0)
                        it.bytes = $urandom_range(60, 1500);
                end else if (pick < 92) begin
                    it.op = OP_READ;
                    if ($urandom_range(0, 7) != 0)
                        it.sel = 4'($urandom_range(0, 8));
                end else if (pick < 95) begin
                    it.op = OP_CLEAR;
                end
                // otherwise a fully random beat, time included
                send_item(it, 1'b0, no_result);
            end
        end
        no_idle = 1'b0;

        // Drain, then let any stray beat show up
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && due_readings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
